/* sv/pme_pkg.sv */
`timescale 1ns / 1ps

package pme_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = 7;
    localparam int ADDR_W       = 2 * VIDX_W;
    localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
    localparam int DATA_W       = 32;
    localparam int RATE_W       = 16;
    localparam int FACTOR_W     = RATE_W + 1;
    localparam int PROD_W       = DATA_W + FACTOR_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = RATE_W;

    localparam logic [DATA_W-1:0]   PHER_ONE  = 32'h0001_0000;
    localparam logic [VCNT_W-1:0]   VCNT_RST  = 7'd64;
    localparam logic [RATE_W-1:0]   RATE_RST  = 16'd6554;

    localparam logic [1:0] ACT_DEPOSIT  = 2'd0;
    localparam logic [1:0] ACT_EVAPORATE = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAP_RATE    = 1'd1;

endpackage

/* sv/pme_ram.sv */
`timescale 1ns / 1ps

module pme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pheromone_matrix_engine_core.sv */
`timescale 1ns / 1ps

// Pheromone matrix engine: 64x64 matrix of unsigned Q16.16 entries in one
// simple dual-port RAM (one write, one registered read per cycle).
// Commands: a transaction is taken when start is high and busy is low.
// i_action selects deposit (adds the amount to (s,d) and (d,s), saturating),
// evaporate (scales every active off-diagonal entry by 1 - rate), or read.
// Every command gives one result on o_pheromone_value / o_index_error,
// marked by o_done for exactly one cycle; the receiver cannot stall.
// Deposit does two read-modify-writes on the single write port; evaporate
// takes one entry per cycle, with n the active vertex count, through a read /
// multiply / write pipeline. An out-of-range or unused command, or an
// evaporate when n is 0, gives its result without leaving idle.
// A new command can be taken in the cycle o_done is high.
// Configuration: i_cfg_we writes vertex_count (index 0) or
// evaporation_rate (index 1), taking effect at once; write only when idle.
// Reset: a clearing pass writes 1.0 into all 4096 entries, one per cycle;
// busy stays high for the whole pass. Config writes are taken meanwhile.

module pheromone_matrix_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic [pme_pkg::VIDX_W-1:0]        i_source_vertex,
    input  logic [pme_pkg::VIDX_W-1:0]        i_dest_vertex,
    input  logic [pme_pkg::DATA_W-1:0]        i_deposit_amount,
    output logic                              o_done,
    output logic [pme_pkg::DATA_W-1:0]        o_pheromone_value,
    output logic                              o_index_error,
    input  logic                              i_cfg_we,
    input  logic [pme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pme_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEP1  = 3'd2;
    localparam logic [2:0] S_DEP2  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EVAP  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [2:0]                       r_state;
    logic [pme_pkg::ADDR_W-1:0]       r_clr;
    logic [pme_pkg::VCNT_W-1:0]       r_vcnt;
    logic [pme_pkg::RATE_W-1:0]       r_rate;
    logic [pme_pkg::VIDX_W-1:0]       r_s;
    logic [pme_pkg::VIDX_W-1:0]       r_d;
    logic [pme_pkg::DATA_W-1:0]       r_amt;
    logic [pme_pkg::DATA_W-1:0]       r_fwd;
    logic [pme_pkg::VIDX_W-1:0]       r_ei;
    logic [pme_pkg::VIDX_W-1:0]       r_ej;
    logic                             r_p1_v;
    logic                             r_p1_wr;
    logic [pme_pkg::ADDR_W-1:0]       r_p1_addr;
    logic                             r_p2_v;
    logic [pme_pkg::ADDR_W-1:0]       r_p2_addr;
    logic [pme_pkg::PROD_W-1:0]       r_p2_prod;
    logic                             r_done;
    logic [pme_pkg::DATA_W-1:0]       r_value;
    logic                             r_err;

    logic [pme_pkg::VCNT_W-1:0]       w_n;
    logic [pme_pkg::VIDX_W-1:0]       w_last;
    logic [pme_pkg::FACTOR_W-1:0]     w_factor;
    logic                             w_accept;
    logic                             w_range_err;
    logic [pme_pkg::DATA_W-1:0]       w_add_a;
    logic [pme_pkg::DATA_W:0]         w_sum_full;
    logic [pme_pkg::DATA_W-1:0]       w_sum;

    logic                             w_we;
    logic [pme_pkg::ADDR_W-1:0]       w_waddr;
    logic [pme_pkg::DATA_W-1:0]       w_wdata;
    logic [pme_pkg::ADDR_W-1:0]       w_raddr;
    logic [pme_pkg::DATA_W-1:0]       w_rdata;

    assign w_n = (r_vcnt > pme_pkg::VCNT_W'(pme_pkg::MAX_VERTICES))
               ? pme_pkg::VCNT_W'(pme_pkg::MAX_VERTICES) : r_vcnt;
    assign w_last   = pme_pkg::VIDX_W'(w_n - pme_pkg::VCNT_W'(1));
    assign w_factor = pme_pkg::FACTOR_W'(1 << pme_pkg::RATE_W)
                    - {1'b0, r_rate};

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_range_err = ({1'b0, i_source_vertex} >= w_n)
                      || ({1'b0, i_dest_vertex} >= w_n);

    // second half of a diagonal deposit must see the first write
    assign w_add_a    = (r_state == S_DEP2 && r_s == r_d) ? r_fwd : w_rdata;
    assign w_sum_full = {1'b0, w_add_a} + {1'b0, r_amt};
    assign w_sum      = w_sum_full[pme_pkg::DATA_W] ? '1
                      : w_sum_full[pme_pkg::DATA_W-1:0];

    always_comb begin
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = pme_pkg::PHER_ONE;
            end
            S_DEP1: begin
                w_we    = 1'b1;
                w_waddr = {r_s, r_d};
                w_wdata = w_sum;
            end
            S_DEP2: begin
                w_we    = 1'b1;
                w_waddr = {r_d, r_s};
                w_wdata = w_sum;
            end
            default: begin
                w_we    = r_p2_v;
                w_waddr = r_p2_addr;
                w_wdata = r_p2_prod[pme_pkg::DATA_W+pme_pkg::RATE_W-1:pme_pkg::RATE_W];
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = {i_source_vertex, i_dest_vertex};
            S_DEP1:  w_raddr = {r_d, r_s};
            S_EVAP:  w_raddr = {r_ei, r_ej};
            default: w_raddr = {r_s, r_d};
        endcase
    end

    pme_ram #(
        .WIDTH (pme_pkg::DATA_W),
        .DEPTH (pme_pkg::DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= pme_pkg::VCNT_RST;
            r_rate <= pme_pkg::RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pme_pkg::CFG_VERTEX_COUNT: r_vcnt <= i_cfg_wdata[pme_pkg::VCNT_W-1:0];
                pme_pkg::CFG_EVAP_RATE:    r_rate <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // evaporate pipeline payload and deposit forwarding register
    always_ff @(posedge i_clk) begin
        r_p2_addr <= r_p1_addr;
        r_p2_prod <= pme_pkg::PROD_W'(w_rdata) * pme_pkg::PROD_W'(w_factor);
        if (r_state == S_DEP1) begin
            r_fwd <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_ei      <= '0;
            r_ej      <= '0;
            r_p1_v    <= 1'b0;
            r_p1_wr   <= 1'b0;
            r_p1_addr <= '0;
            r_p2_v    <= 1'b0;
            r_done    <= 1'b0;
            r_value   <= '0;
            r_err     <= 1'b0;
            r_s       <= '0;
            r_d       <= '0;
            r_amt     <= '0;
        end else begin
            r_done <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= r_p1_v && r_p1_wr;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_s     <= i_source_vertex;
                        r_d     <= i_dest_vertex;
                        r_amt   <= i_deposit_amount;
                        r_value <= '0;
                        r_err   <= 1'b0;
                        r_ei    <= '0;
                        r_ej    <= '0;
                        priority if ((i_action == pme_pkg::ACT_DEPOSIT
                                      || i_action == pme_pkg::ACT_READ) && w_range_err) begin
                            r_err  <= 1'b1;
                            r_done <= 1'b1;
                        end else if (i_action == pme_pkg::ACT_DEPOSIT) begin
                            r_state <= S_DEP1;
                        end else if (i_action == pme_pkg::ACT_READ) begin
                            r_state <= S_READ;
                        end else if (i_action == pme_pkg::ACT_EVAPORATE && w_n != '0) begin
                            r_state <= S_EVAP;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_DEP1: begin
                    r_state <= S_DEP2;
                end
                S_DEP2: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    r_value <= w_rdata;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_EVAP: begin
                    r_p1_v    <= 1'b1;
                    r_p1_wr   <= (r_ei != r_ej);
                    r_p1_addr <= {r_ei, r_ej};
                    if (r_ej == w_last) begin
                        r_ej <= '0;
                        if (r_ei == w_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_ei <= r_ei + 1'b1;
                        end
                    end else begin
                        r_ej <= r_ej + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // last entry is in the write stage this cycle; it is diagonal, so not written
                    if (!r_p1_v) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done            = r_done;
    assign o_pheromone_value = r_value;
    assign o_index_error     = r_err;

endmodule
